// ----- design/der_time_to_epoch_defines.svh -----
// Assertion macros for the checker file of this block.
`ifndef DER_TIME_TO_EPOCH_DEFINES_SVH
`define DER_TIME_TO_EPOCH_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and muted while rst_ni is low.
`define DTTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and muted while rst_ni is low.
`define DTTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/dtte_pkg.sv -----
`default_nettype none

package dtte_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_LEN_FORM = 3'd1,
    ST_TAG      = 3'd2,
    ST_BODY_LEN = 3'd3,
    ST_TRUNC    = 3'd4,
    ST_DIGIT    = 3'd5,
    ST_RANGE    = 3'd6
  } status_e;

  // Parser phases of the front end.
  typedef enum logic [2:0] {
    PH_TAG  = 3'd0,
    PH_LEN1 = 3'd1,
    PH_LENN = 3'd2,
    PH_BODY = 3'd3,
    PH_DROP = 3'd4
  } phase_e;

  // Sequencer states of the date arithmetic.
  typedef enum logic [2:0] {
    BK_IDLE = 3'd0,
    BK_QUO  = 3'd1,
    BK_BASE = 3'd2,
    BK_DAYS = 3'd3,
    BK_MUL  = 3'd4,
    BK_OUT  = 3'd5
  } bk_state_e;

  localparam logic [7:0]  TAG_UTC      = 8'h17;
  localparam logic [7:0]  TAG_GEN      = 8'h18;
  localparam logic [7:0]  CHAR_ZERO    = 8'h30;
  localparam logic [7:0]  CHAR_NINE    = 8'h39;
  localparam logic [7:0]  CHAR_Z       = 8'h5A;
  localparam logic [31:0] LEN_MIN_LONG = 32'h0000_0080;
  localparam logic [31:0] LEN_MAX      = 32'h00FF_FFFF;
  localparam logic [31:0] BODY_LEN_UTC = 32'd13;
  localparam logic [31:0] BODY_LEN_GEN = 32'd15;
  localparam logic [13:0] UTC_PIVOT    = 14'd50;
  // floor(y / 100) = (y * 5243) >> 19, exact for y below 2^14.
  localparam logic [26:0] RECIP_100    = 27'd5243;
  localparam int          RECIP_SHIFT  = 19;
  // One era of 146097 days plus the 719468 days from 0000-03-01 to 1970-01-01.
  localparam logic [23:0] DAYS_OFFSET  = 24'd865565;
  localparam logic signed [17:0] SECS_PER_DAY = 18'sd86400;

  // One parsed element handed from the front end to the arithmetic.
  typedef struct packed {
    status_e     code;
    logic        gen;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } rec_t;

  // Day of the year counted from 1 March for the first day of a month.
  function automatic logic [8:0] march_doy(input logic [3:0] month);
    logic [8:0] r;
    case (month)
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/dtte_if.sv -----
`default_nettype none

// Byte stream into the block.
interface dtte_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

// Decoded time results out of the block.
interface dtte_time_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [38:0] unix_secs;
  logic               is_generalized;

  modport source (output valid, output status, output unix_secs,
                  output is_generalized, input ready);
  modport sink (input valid, input status, input unix_secs,
                input is_generalized, output ready);
endinterface

`default_nettype wire

// ----- design/dtte_front.sv -----
`default_nettype none

module dtte_front
  import dtte_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  dtte_byte_if.sink     in_i,
  output logic          push_valid_o,
  input  wire logic     push_ready_i,
  output rec_t          push_rec_o
);

  phase_e      phase_q, phase_d;
  logic        gen_q, gen_d;
  logic [2:0]  lbl_q, lbl_d;
  logic [31:0] lv_q, lv_d;
  logic [3:0]  bi_q, bi_d;
  logic [3:0]  pd_q, pd_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  month_q, month_d;
  logic [6:0]  day_q, day_d;
  logic [6:0]  hour_q, hour_d;
  logic [6:0]  minute_q, minute_d;
  logic [6:0]  second_q, second_d;
  logic        de_q, de_d;

  logic        accept;
  logic        emit;
  status_e     emit_code;
  logic [7:0]  b;
  logic        be;
  logic        is_digit;
  logic [3:0]  digit;
  logic [3:0]  ystart;
  logic [3:0]  k;
  logic [6:0]  pair_val;
  logic [13:0] year_next;
  logic [31:0] lv_next;
  logic        last_byte;
  logic        range_bad;

  assign b         = in_i.data_byte;
  assign be        = in_i.buffer_end;
  assign accept    = in_i.valid && in_i.ready;
  assign is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  assign digit     = is_digit ? 4'(b - CHAR_ZERO) : 4'd0;
  assign ystart    = gen_q ? 4'd4 : 4'd2;
  assign k         = bi_q - ystart;
  assign pair_val  = 7'(7'(pd_q) * 7'd10 + 7'(digit));
  assign year_next = 14'(year_q * 14'd10 + 14'(digit));
  assign lv_next   = {lv_q[23:0], b};
  assign last_byte = bi_q >= (gen_q ? 4'd14 : 4'd12);
  assign range_bad = (month_q < 7'd1) || (month_q > 7'd12) ||
                     (day_q < 7'd1) || (day_q > 7'd31) ||
                     (hour_q > 7'd23) || (minute_q > 7'd59) || (second_q > 7'd60);

  // Next-state logic: parse one byte, decide whether it closes an element.
  always_comb begin
    logic        err;
    status_e     err_code;
    logic        sb_go;
    logic [31:0] sb_len;
    logic        ok_done;
    err      = 1'b0;
    err_code = ST_OK;
    sb_go    = 1'b0;
    sb_len   = '0;
    ok_done  = 1'b0;
    phase_d  = phase_q;
    gen_d    = gen_q;
    lbl_d    = lbl_q;
    lv_d     = lv_q;
    bi_d     = bi_q;
    pd_d     = pd_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    de_d     = de_q;

    unique case (phase_q)
      PH_TAG: begin
        if (b == TAG_UTC || b == TAG_GEN) begin
          gen_d   = (b == TAG_GEN);
          phase_d = PH_LEN1;
          if (be) begin
            err      = 1'b1;
            err_code = ST_TRUNC;
          end
        end else begin
          gen_d    = 1'b0;
          err      = 1'b1;
          err_code = ST_TAG;
        end
      end
      PH_LEN1: begin
        if (b[7]) begin
          if (b[6:0] == 7'd0 || b[6:0] > 7'd4) begin
            err      = 1'b1;
            err_code = ST_LEN_FORM;
          end else begin
            lbl_d   = b[2:0];
            lv_d    = '0;
            phase_d = PH_LENN;
            if (be) begin
              err      = 1'b1;
              err_code = ST_TRUNC;
            end
          end
        end else begin
          lv_d   = {24'd0, b};
          sb_go  = 1'b1;
          sb_len = {24'd0, b};
        end
      end
      PH_LENN: begin
        if (lv_q == 32'd0 && b == 8'd0) begin
          err      = 1'b1;
          err_code = ST_LEN_FORM;
        end else begin
          lv_d  = lv_next;
          lbl_d = lbl_q - 3'd1;
          if (lbl_d != 3'd0) begin
            if (be) begin
              err      = 1'b1;
              err_code = ST_TRUNC;
            end
          end else if (lv_next > LEN_MAX || lv_next < LEN_MIN_LONG) begin
            err      = 1'b1;
            err_code = ST_LEN_FORM;
          end else begin
            sb_go  = 1'b1;
            sb_len = lv_next;
          end
        end
      end
      PH_BODY: begin
        if (last_byte) begin
          if (de_q || b != CHAR_Z) begin
            err      = 1'b1;
            err_code = ST_DIGIT;
          end else if (range_bad) begin
            err      = 1'b1;
            err_code = ST_RANGE;
          end else begin
            ok_done = 1'b1;
          end
        end else begin
          if (!is_digit) begin
            de_d = 1'b1;
          end
          if (bi_q < ystart) begin
            year_d = year_next;
          end else if (!k[0]) begin
            pd_d = digit;
          end else begin
            case (k[3:1])
              3'd0:    month_d  = pair_val;
              3'd1:    day_d    = pair_val;
              3'd2:    hour_d   = pair_val;
              3'd3:    minute_d = pair_val;
              default: second_d = pair_val;
            endcase
          end
          bi_d = bi_q + 4'd1;
          if (be) begin
            err      = 1'b1;
            err_code = ST_TRUNC;
          end
        end
      end
      PH_DROP: begin
        if (be) begin
          phase_d = PH_TAG;
        end
      end
      default: begin
        phase_d = PH_TAG;
      end
    endcase

    // The length is known: check it against the element type and open the body.
    if (sb_go) begin
      if (sb_len != (gen_q ? BODY_LEN_GEN : BODY_LEN_UTC)) begin
        err      = 1'b1;
        err_code = ST_BODY_LEN;
      end else begin
        phase_d = PH_BODY;
        bi_d    = '0;
        de_d    = 1'b0;
        pd_d    = '0;
        year_d  = '0;
        if (be) begin
          err      = 1'b1;
          err_code = ST_TRUNC;
        end
      end
    end

    emit      = err || ok_done;
    emit_code = err ? err_code : ST_OK;
    if (err) begin
      phase_d = be ? PH_TAG : PH_DROP;
    end else if (ok_done) begin
      phase_d = PH_TAG;
    end
  end

  // Output logic: the queue must have room before any byte is taken.
  always_comb begin
    in_i.ready        = push_ready_i;
    push_valid_o      = in_i.valid && emit;
    push_rec_o.code   = emit_code;
    push_rec_o.gen    = gen_d;
    push_rec_o.year   = year_q;
    push_rec_o.month  = month_q;
    push_rec_o.day    = day_q;
    push_rec_o.hour   = hour_q;
    push_rec_o.minute = minute_q;
    push_rec_o.second = second_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TAG;
      gen_q    <= 1'b0;
      lbl_q    <= '0;
      lv_q     <= '0;
      bi_q     <= '0;
      pd_q     <= '0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      de_q     <= 1'b0;
    end else if (accept) begin
      phase_q  <= phase_d;
      gen_q    <= gen_d;
      lbl_q    <= lbl_d;
      lv_q     <= lv_d;
      bi_q     <= bi_d;
      pd_q     <= pd_d;
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      de_q     <= de_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/dtte_queue.sv -----
`default_nettype none

module dtte_queue
  import dtte_pkg::*;
#(
  parameter int Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire rec_t push_rec_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output rec_t      pop_rec_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign pop_rec_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/dtte_back.sv -----
`default_nettype none

module dtte_back
  import dtte_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   pop_valid_i,
  output logic        pop_ready_o,
  input  wire rec_t   pop_rec_i,
  dtte_time_if.source out_o
);

  bk_state_e          state_q, state_d;
  status_e            code_q;
  logic               gen_q;
  logic [13:0]        y3_q, y3_d;
  logic [3:0]         month_q;
  logic [4:0]         day_q;
  logic [4:0]         hour_q;
  logic [5:0]         minute_q;
  logic [5:0]         second_q;
  logic [6:0]         q100_q;
  logic [8:0]         doy_q;
  logic [16:0]        tod_q;
  logic [21:0]        base_q;
  logic signed [23:0] days_q;
  logic signed [38:0] prod_q;
  logic               out_valid_q;
  logic [2:0]         out_status_q;
  logic signed [38:0] out_epoch_q;
  logic               out_gen_q;

  logic               take;
  logic               load_out;
  logic [13:0]        year_full;
  logic [26:0]        qprod;
  logic signed [41:0] prod_full;

  // Full year, then shifted by one era so that the January and February of
  // year zero stay non-negative.
  assign year_full = pop_rec_i.gen ? pop_rec_i.year :
                     (pop_rec_i.year < UTC_PIVOT) ? pop_rec_i.year + 14'd2000 :
                                                    pop_rec_i.year + 14'd1900;
  assign y3_d      = year_full + 14'd400 - ((pop_rec_i.month <= 7'd2) ? 14'd1 : 14'd0);
  assign qprod     = 27'(y3_q) * RECIP_100;
  assign prod_full = days_q * SECS_PER_DAY;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (pop_valid_i) begin
          state_d = (pop_rec_i.code == ST_OK) ? BK_QUO : BK_OUT;
        end
      end
      BK_QUO:  state_d = BK_BASE;
      BK_BASE: state_d = BK_DAYS;
      BK_DAYS: state_d = BK_MUL;
      BK_MUL:  state_d = BK_OUT;
      BK_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    pop_ready_o          = state_q == BK_IDLE;
    take                 = pop_valid_i && pop_ready_o;
    load_out             = (state_q == BK_OUT) && (!out_valid_q || out_o.ready);
    out_o.valid          = out_valid_q;
    out_o.status         = out_status_q;
    out_o.unix_secs      = out_epoch_q;
    out_o.is_generalized = out_gen_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      code_q   <= pop_rec_i.code;
      gen_q    <= pop_rec_i.gen;
      y3_q     <= y3_d;
      month_q  <= pop_rec_i.month[3:0];
      day_q    <= pop_rec_i.day[4:0];
      hour_q   <= pop_rec_i.hour[4:0];
      minute_q <= pop_rec_i.minute[5:0];
      second_q <= pop_rec_i.second[5:0];
    end
    if (state_q == BK_QUO) begin
      q100_q <= qprod[RECIP_SHIFT+6:RECIP_SHIFT];
      doy_q  <= march_doy(month_q) + 9'(day_q) - 9'd1;
      tod_q  <= 17'(hour_q) * 17'd3600 + 17'(minute_q) * 17'd60 + 17'(second_q);
    end
    if (state_q == BK_BASE) begin
      base_q <= 22'(y3_q) * 22'd365 + 22'(y3_q[13:2]) + 22'(doy_q);
    end
    if (state_q == BK_DAYS) begin
      days_q <= {2'b00, base_q} - 24'(q100_q) + 24'(q100_q[6:2]) - DAYS_OFFSET;
    end
    if (state_q == BK_MUL) begin
      prod_q <= prod_full[38:0];
    end
    if (load_out) begin
      out_status_q <= code_q;
      out_gen_q    <= gen_q;
      out_epoch_q  <= (code_q == ST_OK) ? prod_q + 39'(tod_q) : '0;
    end
  end

endmodule

`default_nettype wire

// ----- design/der_time_to_epoch.sv -----
// Path: the closing byte writes a record into the queue; the back end takes it
// in IDLE, steps through QUO, BASE, DAYS and MUL for a well-formed element, and
// loads the result register in OUT; an error goes from IDLE straight to OUT.
// Throughput: one byte per cycle while the element queue has room.
// Reset: rst_ni clears the parser phase, the queue pointers and the output valid
// at once; no clearing pass follows and bytes are taken as soon as it is released.
`default_nettype none

// DER UTCTime / GeneralizedTime element to signed Unix seconds.
//
// The front end walks the tag, the length bytes and the body one byte per
// cycle while the queue has room. It checks the tag, the canonical length
// form, the body length, the digits, the closing Z and the field ranges, and
// on the byte that closes an element (or on the first error) it writes one
// record into a short queue. After an error it drops bytes until buffer end.
//
// The back end pops one record at a time. For a good record it works out the
// day count from 1 March of year zero in steps: a reciprocal multiply for the
// century count, then the day base, the era correction, and finally the
// multiply by the seconds in a day. Errors skip the arithmetic and leave
// with zero seconds. The result waits in an output register, and the back end
// keeps working on the next record while it is held.
module der_time_to_epoch
  import dtte_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dtte_byte_if.sink   in_i,
  dtte_time_if.source out_o
);

  logic push_valid;
  logic push_ready;
  rec_t push_rec;
  logic pop_valid;
  logic pop_ready;
  rec_t pop_rec;

  dtte_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_rec_o   (push_rec)
  );

  dtte_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_rec_i   (push_rec),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_rec_o    (pop_rec)
  );

  dtte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_rec_i   (pop_rec),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ----- design/dtte_checker.sv -----
`default_nettype none

`include "der_time_to_epoch_defines.svh"

module dtte_checker
  import dtte_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [2:0]  out_status_i,
  input wire logic [38:0] out_epoch_i,
  input wire logic        out_gen_i
);

  // A held item keeps its whole payload.
  `DTTE_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_status_i) && $stable(out_epoch_i) && $stable(out_gen_i),
    "result changed while stalled")

  // Error items carry zero seconds.
  `DTTE_ASSERT_NOW(a_err_zero, out_valid_i && out_status_i != ST_OK,
    out_epoch_i == '0, "error item with non-zero seconds")

  // A wrong tag is never reported as GeneralizedTime.
  `DTTE_ASSERT_NOW(a_tag_gen, out_valid_i && out_status_i == ST_TAG,
    !out_gen_i, "wrong-tag item flagged as GeneralizedTime")

  // Status codes stay within the defined set.
  `DTTE_ASSERT_NOW(a_status_range, out_valid_i,
    out_status_i <= ST_RANGE, "undefined status code")

endmodule

bind der_time_to_epoch dtte_checker u_dtte_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_epoch_i  (out_o.unix_secs),
  .out_gen_i    (out_o.is_generalized)
);

`default_nettype wire

// ----- tb/der_time_to_epoch_test.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the DER time element decoder.
//
// The stimulus process pushes bytes through the byte channel one item at a
// time. Every byte that the block accepts is also fed to a parser that lives
// in this file, and that parser decides whether the byte closes an element
// (or raises an error). Where it does, the expected result is queued in
// pending_times. The checker pops the oldest entry each time the block hands
// over a result, and compares it field by field.
module der_time_to_epoch_test;
  import dtte_pkg::*;

  // One expected result as it leaves the block.
  typedef struct packed {
    status_e            st;
    logic signed [38:0] secs;
    logic               gen;
  } time_res_t;

  // One row of the directed table. The header (tag and length bytes) and the
  // body are both right-justified, so the first byte sits highest. When ends
  // is set the last byte of the row carries buffer_end. When typed is set the
  // result in res is pushed as it stands instead of the parser's own.
  typedef struct packed {
    logic [2:0]   hdr_n;
    logic [47:0]  hdr;
    logic [3:0]   body_n;
    logic [119:0] body;
    logic         ends;
    logic         typed;
    time_res_t    res;
  } dir_row_t;

  localparam int        DIR_ROWS_N  = 25;
  localparam int        RAND_BYTES  = 250;
  localparam int        DRAIN_WAIT  = 20;
  localparam time_res_t NO_RES      = '{ST_OK, 39'sd0, 1'b0};

  // Directed part: the extremes of the date range, the two-digit year pivot,
  // a day that overflows a short month, every range check but the one on a day
  // above 31, every error code, and the length forms that must be refused.
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    // The Unix epoch itself, straight after reset.
    '{3'd2, 48'h170D, 4'd13, "700101000000Z", 1'b0, 1'b1, '{ST_OK, 39'sd0, 1'b0}},
    // The earliest and the latest instants that GeneralizedTime can carry.
    '{3'd2, 48'h180F, 4'd15, "00000101000000Z", 1'b0, 1'b1,
      '{ST_OK, -39'sd62167219200, 1'b1}},
    '{3'd2, 48'h180F, 4'd15, "99991231235960Z", 1'b1, 1'b1,
      '{ST_OK, 39'sd253402300800, 1'b1}},
    // Either side of the UTCTime century pivot.
    '{3'd2, 48'h170D, 4'd13, "491231235959Z", 1'b0, 1'b0, NO_RES},
    '{3'd2, 48'h170D, 4'd13, "500101000000Z", 1'b1, 1'b0, NO_RES},
    // The 31st of February is let through and runs on into March.
    '{3'd2, 48'h180F, 4'd15, "20240231120000Z", 1'b0, 1'b0, NO_RES},
    // Field range errors, one field at a time.
    '{3'd2, 48'h180F, 4'd15, "19700001000000Z", 1'b1, 1'b1, '{ST_RANGE, 39'sd0, 1'b1}},
    '{3'd2, 48'h170D, 4'd13, "701301000000Z", 1'b1, 1'b1, '{ST_RANGE, 39'sd0, 1'b0}},
    '{3'd2, 48'h170D, 4'd13, "700100000000Z", 1'b1, 1'b1, '{ST_RANGE, 39'sd0, 1'b0}},
    '{3'd2, 48'h170D, 4'd13, "700101240000Z", 1'b1, 1'b1, '{ST_RANGE, 39'sd0, 1'b0}},
    '{3'd2, 48'h170D, 4'd13, "700101006000Z", 1'b1, 1'b1, '{ST_RANGE, 39'sd0, 1'b0}},
    '{3'd2, 48'h170D, 4'd13, "700101000061Z", 1'b1, 1'b1, '{ST_RANGE, 39'sd0, 1'b0}},
    // A letter among the digits, then a missing closing Z.
    '{3'd2, 48'h170D, 4'd13, "7001010000A0Z", 1'b1, 1'b1, '{ST_DIGIT, 39'sd0, 1'b0}},
    '{3'd2, 48'h180F, 4'd15, "19700101000000Y", 1'b1, 1'b1, '{ST_DIGIT, 39'sd0, 1'b1}},
    // Wrong tags; the second one sits on the last byte of its buffer.
    '{3'd2, 48'h300D, 4'd13, "700101000000Z", 1'b1, 1'b1, '{ST_TAG, 39'sd0, 1'b0}},
    '{3'd1, 48'hFF, 4'd0, 120'd0, 1'b1, 1'b1, '{ST_TAG, 39'sd0, 1'b0}},
    // Refused length forms: indefinite, too many length bytes, a leading
    // zero, a long form under 0x80, and a value above the ceiling.
    '{3'd2, 48'h1780, 4'd13, "700101000000Z", 1'b1, 1'b1, '{ST_LEN_FORM, 39'sd0, 1'b0}},
    '{3'd2, 48'h1885, 4'd15, "19700101000000Z", 1'b1, 1'b1,
      '{ST_LEN_FORM, 39'sd0, 1'b1}},
    '{3'd4, 48'h1882000F, 4'd15, "19700101000000Z", 1'b1, 1'b1,
      '{ST_LEN_FORM, 39'sd0, 1'b1}},
    '{3'd3, 48'h17810D, 4'd13, "700101000000Z", 1'b1, 1'b1,
      '{ST_LEN_FORM, 39'sd0, 1'b0}},
    '{3'd6, 48'h188401000000, 4'd15, "19700101000000Z", 1'b1, 1'b1,
      '{ST_LEN_FORM, 39'sd0, 1'b1}},
    // A canonical long form that still has the wrong body length, then a
    // UTCTime that claims a GeneralizedTime length.
    '{3'd3, 48'h178180, 4'd0, 120'd0, 1'b1, 1'b1, '{ST_BODY_LEN, 39'sd0, 1'b0}},
    '{3'd2, 48'h170F, 4'd13, "700101000000Z", 1'b1, 1'b1,
      '{ST_BODY_LEN, 39'sd0, 1'b0}},
    // The buffer runs out inside the body, and straight after the tag.
    '{3'd2, 48'h180F, 4'd4, "2024", 1'b1, 1'b1, '{ST_TRUNC, 39'sd0, 1'b1}},
    '{3'd1, 48'h17, 4'd0, 120'd0, 1'b1, 1'b1, '{ST_TRUNC, 39'sd0, 1'b0}}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dtte_byte_if in_bus ();
  dtte_time_if out_bus ();

  der_time_to_epoch u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #6 clk_i = ~clk_i;

  // Results still owed by the block, oldest first.
  time_res_t pending_times [$];
  time_res_t want;
  int unsigned n_mismatches = 0;

  // While a calm flag is set that side of the block runs without any idling.
  bit calm_in  = 1'b0;
  bit calm_out = 1'b0;

  // Bytes of the element being built by the random part, {buffer_end, byte}.
  logic [8:0] elem_q [$];

  // ---------------------------------------------------------------------
  // Parser state, a copy of the block's own front end.
  // ---------------------------------------------------------------------
  phase_e      ps_phase;
  logic        ps_gen;
  logic [2:0]  ps_len_left;
  logic [31:0] ps_len;
  logic [3:0]  ps_idx;
  logic [3:0]  ps_pend;
  logic [13:0] ps_year;
  logic [6:0]  ps_month;
  logic [6:0]  ps_day;
  logic [6:0]  ps_hour;
  logic [6:0]  ps_min;
  logic [6:0]  ps_sec;
  logic        ps_bad_char;

  task automatic reset_parser();
    ps_phase    = PH_TAG;
    ps_gen      = 1'b0;
    ps_len_left = '0;
    ps_len      = '0;
    ps_idx      = '0;
    ps_pend     = '0;
    ps_year     = '0;
    ps_month    = '0;
    ps_day      = '0;
    ps_hour     = '0;
    ps_min      = '0;
    ps_sec      = '0;
    ps_bad_char = 1'b0;
  endtask

  // Days from 1970-01-01 to the given proleptic Gregorian date, counted in
  // 400-year eras that start on 1 March of year zero.
  function automatic longint civil_day_count(longint y, longint m, longint d);
    longint y2, era, yoe, mp, doy, doe;
    y2  = y - ((m <= 2) ? 1 : 0);
    era = ((y2 >= 0) ? y2 : y2 - 399) / 400;
    yoe = y2 - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  // An error result: seconds are zero, and the rest of the buffer is
  // dropped unless this byte already ends it.
  task automatic raise_error(input status_e code, input logic be, output time_res_t r);
    r.st   = code;
    r.secs = '0;
    r.gen  = ps_gen;
    ps_phase = be ? PH_TAG : PH_DROP;
  endtask

  // The length is complete: check it against the element type and open the body.
  task automatic open_body(input logic be, output bit got, output time_res_t r);
    got = 1'b0;
    r   = NO_RES;
    if (ps_len != (ps_gen ? 32'd15 : 32'd13)) begin
      got = 1'b1;
      raise_error(ST_BODY_LEN, be, r);
    end else begin
      ps_phase    = PH_BODY;
      ps_idx      = '0;
      ps_bad_char = 1'b0;
      ps_pend     = '0;
      ps_year     = '0;
      if (be) begin
        got = 1'b1;
        raise_error(ST_TRUNC, be, r);
      end
    end
  endtask

  // One digit position of the body. A non-digit counts as zero and is
  // remembered until the closing byte.
  task automatic take_digit(input logic [7:0] b);
    logic [3:0] d;
    logic [3:0] k;
    logic [6:0] v;
    int         ystart;
    ystart = ps_gen ? 4 : 2;
    d = '0;
    if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
      d = 4'(b - CHAR_ZERO);
    end else begin
      ps_bad_char = 1'b1;
    end
    if (ps_idx < ystart) begin
      ps_year = 14'(ps_year * 10 + d);
    end else begin
      k = 4'(ps_idx - ystart);
      if (!k[0]) begin
        ps_pend = d;
      end else begin
        v = 7'(ps_pend * 10 + d);
        case (k >> 1)
          4'd0:    ps_month = v;
          4'd1:    ps_day   = v;
          4'd2:    ps_hour  = v;
          4'd3:    ps_min   = v;
          default: ps_sec   = v;
        endcase
      end
    end
  endtask

  // The closing byte of the body: Z check, range checks, then the seconds.
  task automatic close_body(input logic [7:0] b, input logic be, output time_res_t r);
    longint yv, secs;
    if (b != CHAR_Z) begin
      ps_bad_char = 1'b1;
    end
    if (ps_bad_char) begin
      raise_error(ST_DIGIT, be, r);
    end else if (ps_month < 1 || ps_month > 12 || ps_day < 1 || ps_day > 31 ||
                 ps_hour > 23 || ps_min > 59 || ps_sec > 60) begin
      raise_error(ST_RANGE, be, r);
    end else begin
      yv = longint'(ps_year);
      if (!ps_gen) begin
        yv = (ps_year < 14'd50) ? yv + 2000 : yv + 1900;
      end
      secs = civil_day_count(yv, longint'(ps_month), longint'(ps_day)) * 86400
           + longint'(ps_hour) * 3600 + longint'(ps_min) * 60 + longint'(ps_sec);
      r.st   = ST_OK;
      r.secs = secs[38:0];
      r.gen  = ps_gen;
      ps_phase = PH_TAG;
    end
  endtask

  // Advances the parser by one accepted byte. got tells whether the byte
  // produces a result, which is then returned in r.
  task automatic parse_der_byte(input logic [7:0] b, input logic be,
                                output bit got, output time_res_t r);
    logic [6:0] n;
    got = 1'b0;
    r   = NO_RES;
    case (ps_phase)
      PH_TAG: begin
        if (b == TAG_UTC || b == TAG_GEN) begin
          ps_gen   = (b == TAG_GEN);
          ps_phase = PH_LEN1;
          if (be) begin
            got = 1'b1;
            raise_error(ST_TRUNC, be, r);
          end
        end else begin
          ps_gen = 1'b0;
          got    = 1'b1;
          raise_error(ST_TAG, be, r);
        end
      end
      PH_LEN1: begin
        if (b[7]) begin
          n = b[6:0];
          if (n == 0 || n > 4) begin
            got = 1'b1;
            raise_error(ST_LEN_FORM, be, r);
          end else begin
            ps_len_left = n[2:0];
            ps_len      = '0;
            ps_phase    = PH_LENN;
            if (be) begin
              got = 1'b1;
              raise_error(ST_TRUNC, be, r);
            end
          end
        end else begin
          ps_len = {24'd0, b};
          open_body(be, got, r);
        end
      end
      PH_LENN: begin
        if (ps_len == 0 && b == 8'd0) begin
          got = 1'b1;
          raise_error(ST_LEN_FORM, be, r);
        end else begin
          ps_len      = {ps_len[23:0], b};
          ps_len_left = ps_len_left - 3'd1;
          if (ps_len_left != 0) begin
            if (be) begin
              got = 1'b1;
              raise_error(ST_TRUNC, be, r);
            end
          end else if (ps_len > 32'h00FF_FFFF || ps_len < 32'h0000_0080) begin
            got = 1'b1;
            raise_error(ST_LEN_FORM, be, r);
          end else begin
            open_body(be, got, r);
          end
        end
      end
      PH_BODY: begin
        if (ps_idx >= (ps_gen ? 4'd14 : 4'd12)) begin
          got = 1'b1;
          close_body(b, be, r);
        end else begin
          take_digit(b);
          ps_idx = ps_idx + 4'd1;
          if (be) begin
            got = 1'b1;
            raise_error(ST_TRUNC, be, r);
          end
        end
      end
      default: begin
        // Dropping after an error until the buffer ends.
        if (be) begin
          ps_phase = PH_TAG;
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Byte side.
  // ---------------------------------------------------------------------

  // Offers one byte after a random pause and holds it until it is taken. The
  // acceptance is seen at the edge itself, so the parser runs in step with
  // the block. Valid gets at most one assignment in any time step.
  task automatic send_byte(input logic [7:0] b, input logic be,
                           input bit use_typed, input time_res_t typed_res);
    int        gap;
    bit        got;
    time_res_t r;
    if ($urandom_range(0, 59) == 0) begin
      calm_in = !calm_in;
    end
    gap = calm_in ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.data_byte  <= b;
    in_bus.buffer_end <= be;
    do @(posedge clk_i); while (!in_bus.ready);
    parse_der_byte(b, be, got, r);
    if (got) begin
      pending_times.push_back(use_typed ? typed_res : r);
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    elem_q.push_back({1'b0, b});
  endtask

  // Appends v as n ASCII digits, most significant first.
  task automatic put_digits(input int unsigned v, input int n);
    int unsigned div;
    div = 1;
    repeat (n - 1) div = div * 10;
    repeat (n) begin
      push_byte(CHAR_ZERO + 8'((v / div) % 10));
      div = div / 10;
    end
  endtask

  // A date or time field: mostly inside its range, now and then any two digits.
  function automatic int unsigned pick_field(int unsigned lo, int unsigned hi);
    if ($urandom_range(0, 11) == 0) begin
      return $urandom_range(0, 99);
    end
    return $urandom_range(hi, lo);
  endfunction

  // Builds one random element into elem_q. Most are well-formed elements
  // with random dates, some spoilt by a random length byte, a stray byte or
  // cut short; the rest are broken headers and plain noise.
  task automatic build_element();
    int          kind, pos, cut, n, sel;
    logic        g;
    int unsigned yr;
    elem_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      g = 1'($urandom_range(0, 1));
      push_byte(g ? TAG_GEN : TAG_UTC);
      if ($urandom_range(0, 15) == 0) begin
        push_byte(8'($urandom_range(0, 127)));
      end else begin
        push_byte(g ? 8'd15 : 8'd13);
      end
      if (g) begin
        sel = $urandom_range(0, 9);
        yr  = (sel == 0) ? 0 : (sel == 1) ? 9999 : $urandom_range(0, 9999);
        put_digits(yr, 4);
      end else begin
        put_digits($urandom_range(0, 99), 2);
      end
      put_digits(pick_field(1, 12), 2);
      put_digits(pick_field(1, 31), 2);
      put_digits(pick_field(0, 23), 2);
      put_digits(pick_field(0, 59), 2);
      put_digits(pick_field(0, 60), 2);
      push_byte(CHAR_Z);
      if ($urandom_range(0, 9) == 0) begin
        // A stray byte somewhere in the body, often just outside '0'..'9'.
        pos = $urandom_range(2, elem_q.size() - 1);
        sel = $urandom_range(0, 2);
        elem_q[pos][7:0] = (sel == 0) ? CHAR_ZERO - 8'd1 :
                           (sel == 1) ? CHAR_NINE + 8'd1 : 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, elem_q.size() - 1);
        while (elem_q.size() > cut) void'(elem_q.pop_back());
        elem_q[elem_q.size() - 1][8] = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        elem_q[elem_q.size() - 1][8] = 1'b1;
      end
    end else if (kind < 85) begin
      sel = $urandom_range(0, 2);
      push_byte((sel == 0) ? TAG_UTC : (sel == 1) ? TAG_GEN : 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) begin
        push_byte(8'h80 | 8'($urandom_range(0, 7)));
      end else begin
        push_byte(8'($urandom_range(0, 255)));
      end
      n = $urandom_range(0, 16);
      repeat (n) push_byte(8'($urandom_range(0, 255)));
      elem_q[elem_q.size() - 1][8] = 1'b1;
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) elem_q.push_back({1'($urandom_range(0, 3) == 0), 8'($urandom_range(0, 255))});
    end
  endtask

  // Reset, the directed table, the random part, then the drain.
  initial begin
    dir_row_t    row;
    int unsigned total, i, r, idx;
    int unsigned n_rand_bytes;
    logic [7:0]  b;
    in_bus.valid      <= 1'b0;
    in_bus.data_byte  <= 8'd0;
    in_bus.buffer_end <= 1'b0;
    reset_parser();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (r = 0; r < DIR_ROWS_N; r++) begin
      row   = DIR_ROWS[r];
      total = row.hdr_n + row.body_n;
      for (i = 0; i < total; i++) begin
        if (i < row.hdr_n) begin
          idx = 8 * (row.hdr_n - 1 - i);
          b   = row.hdr[idx +: 8];
        end else begin
          idx = 8 * (row.body_n - 1 - (i - row.hdr_n));
          b   = row.body[idx +: 8];
        end
        send_byte(b, row.ends && (i == total - 1), row.typed, row.res);
      end
    end

    // The random part stops once enough bytes have gone in.
    n_rand_bytes = 0;
    while (n_rand_bytes < RAND_BYTES) begin
      build_element();
      foreach (elem_q[k]) begin
        send_byte(elem_q[k][7:0], elem_q[k][8], 1'b0, NO_RES);
        n_rand_bytes++;
      end
    end
    in_bus.valid <= 1'b0;

    // Wait for every owed result, then a little longer so that a stray
    // extra result would still be caught.
    while (pending_times.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (n_mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side.
  // ---------------------------------------------------------------------

  // Ready drops for a random stall before each result, and then stays high
  // until a result has been taken.
  initial begin
    int stall;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 59) == 0) begin
        calm_out = !calm_out;
      end
      stall = calm_out ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
    end
  end

  // Reports one mismatch with the time, the expected and the actual value.
  task automatic note_mismatch(input string what, input longint exp_v, input longint got_v);
    $display("%0t ns: %s expected %0d, got %0d", $time, what, exp_v, got_v);
    n_mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_times.size() == 0) begin
        note_mismatch("result with none outstanding, status", -1,
                      longint'(out_bus.status));
      end else begin
        want = pending_times.pop_front();
        if (out_bus.status !== want.st) begin
          note_mismatch("status", longint'(want.st), longint'(out_bus.status));
        end
        if (out_bus.unix_secs !== want.secs) begin
          note_mismatch("unix_secs", longint'(want.secs), longint'(out_bus.unix_secs));
        end
        if (out_bus.is_generalized !== want.gen) begin
          note_mismatch("is_generalized", longint'(want.gen), longint'(out_bus.is_generalized));
        end
      end
    end
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/dtte_pkg.sv
design/dtte_if.sv
design/dtte_front.sv
design/dtte_queue.sv
design/dtte_back.sv
design/der_time_to_epoch.sv
design/dtte_checker.sv
tb/der_time_to_epoch_test.sv
